@@ hdl/base32_symbol_encoder_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the base32 symbol encoder
// Short forms for the checks at the end of the top level. They expect clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BASE32_SYMBOL_ENCODER_CORE_MACROS_SVH
`define BASE32_SYMBOL_ENCODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B32E_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B32E_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/b32e_pkg.sv @@
// ----------------------------------------------------------------------------
// b32e_pkg
// Types and constants shared by the base32 symbol encoder modules.
// ----------------------------------------------------------------------------
package b32e_pkg;

  // Field and state widths.
  localparam int CODE_LEN_W = 7;
  localparam int ACC_W      = 12;
  localparam int HELD_W     = 4;
  localparam int GROUP_W    = 5;
  localparam int SYM_W      = 7;

  // Code length after reset.
  localparam logic [CODE_LEN_W-1:0] CODE_LEN_RESET = 7'd16;

  // Number of bits in one symbol group.
  localparam logic [HELD_W-1:0] GROUP_BITS = 4'd5;

  // Bits added to the accumulator by one byte.
  localparam logic [HELD_W-1:0] BYTE_BITS = 4'd8;

  // Index of the padding symbol '0'.
  localparam logic [GROUP_W-1:0] PAD_INDEX = 5'd0;

  // Crockford alphabet as ASCII codes, index 31 first.
  localparam logic [31:0][SYM_W-1:0] SYMBOL_TABLE = {
    7'd90, 7'd89, 7'd88, 7'd87, 7'd86, 7'd84, 7'd83, 7'd82,
    7'd81, 7'd80, 7'd78, 7'd77, 7'd75, 7'd74, 7'd72, 7'd71,
    7'd70, 7'd69, 7'd68, 7'd67, 7'd66, 7'd65, 7'd57, 7'd56,
    7'd55, 7'd54, 7'd53, 7'd52, 7'd51, 7'd50, 7'd49, 7'd48
  };

  // One input request.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;
  } out_item_t;

  // Operands presented to the group extraction unit.
  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [HELD_W-1:0] held;
    logic              pad;
  } ext_req_t;

  // Result of the group extraction unit.
  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic [ACC_W-1:0]  acc;
    logic [HELD_W-1:0] held;
  } ext_rsp_t;

endpackage

@@ hdl/b32e_extract.sv @@
// ----------------------------------------------------------------------------
// b32e_extract
// Shared shift unit: maps the top five held bits of the accumulator to an
// alphabet symbol (pad symbol when padding), returns the remaining bits.
// ----------------------------------------------------------------------------
module b32e_extract (
  input  b32e_pkg::ext_req_t req,
  output b32e_pkg::ext_rsp_t rsp
);

  logic [b32e_pkg::HELD_W-1:0]  shift_amt;
  logic [b32e_pkg::ACC_W-1:0]   shifted;
  logic [b32e_pkg::ACC_W-1:0]   keep_mask;
  logic [b32e_pkg::GROUP_W-1:0] group_idx;

  // Bits below the group stay in the accumulator.
  assign shift_amt = req.held - b32e_pkg::GROUP_BITS;
  assign shifted   = req.acc >> shift_amt;
  assign keep_mask = (b32e_pkg::ACC_W'(1) << shift_amt) - b32e_pkg::ACC_W'(1);

  // Padding always emits the zero symbol.
  assign group_idx = req.pad ? b32e_pkg::PAD_INDEX : shifted[b32e_pkg::GROUP_W-1:0];

  assign rsp.symbol = b32e_pkg::SYMBOL_TABLE[group_idx];
  assign rsp.acc    = req.acc & keep_mask;
  assign rsp.held   = shift_amt;

endmodule

@@ hdl/b32e_out_stage.sv @@
// ----------------------------------------------------------------------------
// b32e_out_stage
// Output register for result requests. A new symbol may be loaded whenever
// the register is empty or is being taken in the same cycle.
// ----------------------------------------------------------------------------
module b32e_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  b32e_pkg::out_item_t load_data,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output b32e_pkg::out_item_t out_data
);

  logic                valid_r;
  b32e_pkg::out_item_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Valid flag follows loads and departures.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

@@ hdl/base32_symbol_encoder_core.sv @@
// ----------------------------------------------------------------------------
// base32_symbol_encoder_core
// Byte stream to fixed-length Crockford base32 code encoder.
// ----------------------------------------------------------------------------
// Each input request is accepted in idle; a data byte that is encoded then
// produces one or two symbols before the block returns to idle, a byte that
// arrives after the code is complete is dropped, and an end of message adds
// padding symbols up to the code length and then clears the state. The single
// shared group extraction unit yields one symbol per cycle into the output
// register while that register has room, so stalls on the result channel hold
// it back. The block takes no new request until the current one is finished.
// ----------------------------------------------------------------------------
module base32_symbol_encoder_core #(
  parameter int MAX_CODE_LENGTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  b32e_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b32e_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [b32e_pkg::CODE_LEN_W-1:0] cfg_wr_data
);

  `include "base32_symbol_encoder_core_macros.svh"

  localparam logic [b32e_pkg::CODE_LEN_W-1:0] MAX_LEN =
    b32e_pkg::CODE_LEN_W'(MAX_CODE_LENGTH);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EMIT = 2'd1;
  localparam logic [1:0] ST_PAD  = 2'd2;

  logic [1:0]                        state_r, state_nxt;
  logic [b32e_pkg::ACC_W-1:0]        acc_r, acc_nxt;
  logic [b32e_pkg::HELD_W-1:0]       held_r, held_nxt;
  logic [b32e_pkg::CODE_LEN_W-1:0]   sent_r, sent_nxt;
  logic                              eom_r, eom_nxt;
  logic [b32e_pkg::CODE_LEN_W-1:0]   cfg_len_r;
  logic [b32e_pkg::CODE_LEN_W-1:0]   len_eff;
  logic [b32e_pkg::CODE_LEN_W-1:0]   sent_inc;
  logic                              sent_lt;
  logic                              group_ready;
  logic                              take_byte;
  logic                              emit_go;
  logic                              can_load;
  b32e_pkg::ext_req_t                ext_req;
  b32e_pkg::ext_rsp_t                ext_rsp;
  b32e_pkg::out_item_t               emit_item;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= b32e_pkg::CODE_LEN_RESET;
    end else if (cfg_wr_en) begin
      cfg_len_r <= cfg_wr_data;
    end
  end

  // Clamp the configured length into its legal range.
  always_comb begin
    if (cfg_len_r == '0) begin
      len_eff = b32e_pkg::CODE_LEN_W'(1);
    end else if (cfg_len_r > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = cfg_len_r;
    end
  end

  assign sent_lt     = sent_r < len_eff;
  assign sent_inc    = sent_r + b32e_pkg::CODE_LEN_W'(1);
  assign group_ready = held_r >= b32e_pkg::GROUP_BITS;
  assign in_ready    = (state_r == ST_IDLE);
  assign take_byte   = in_data.has_byte && sent_lt;

  // Shared extraction unit.
  assign ext_req.acc  = acc_r;
  assign ext_req.held = held_r;
  assign ext_req.pad  = (state_r == ST_PAD);

  b32e_extract u_extract (
    .req (ext_req),
    .rsp (ext_rsp)
  );

  // A symbol leaves when one is due and the output register has room.
  assign emit_go = can_load && sent_lt &&
                   (((state_r == ST_EMIT) && group_ready) || (state_r == ST_PAD));

  assign emit_item.symbol      = ext_rsp.symbol;
  assign emit_item.last_symbol = (sent_inc == len_eff);

  b32e_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit_go),
    .load_data (emit_item),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Sequencer: load a byte, emit its groups, then pad and clear at message end.
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    held_nxt  = held_r;
    sent_nxt  = sent_r;
    eom_nxt   = eom_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          eom_nxt = in_data.end_of_message;
          if (take_byte) begin
            acc_nxt   = {acc_r[b32e_pkg::HELD_W-1:0], in_data.data_byte};
            held_nxt  = held_r + b32e_pkg::BYTE_BITS;
            state_nxt = ST_EMIT;
          end else if (in_data.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_EMIT: begin
        if (group_ready && sent_lt) begin
          if (emit_go) begin
            acc_nxt  = ext_rsp.acc;
            held_nxt = ext_rsp.held;
            sent_nxt = sent_inc;
          end
        end else begin
          state_nxt = eom_r ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        if (sent_lt) begin
          if (emit_go) begin
            sent_nxt = sent_inc;
          end
        end else begin
          acc_nxt   = '0;
          held_nxt  = '0;
          sent_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer and encoder state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      acc_r   <= '0;
      held_r  <= '0;
      sent_r  <= '0;
      eom_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      held_r  <= held_nxt;
      sent_r  <= sent_nxt;
      eom_r   <= eom_nxt;
    end
  end

  // A symbol is only produced while the code is still short of its length.
  `B32E_ASSERT_SAME(a_emit_within_len, emit_go, sent_r < len_eff, "symbol emitted past code length")

  // The symbol flagged as last brings the count exactly to the length.
  `B32E_ASSERT_NEXT(a_last_matches_len, emit_go && emit_item.last_symbol, sent_r == len_eff, "last symbol does not complete the code")

  // Finishing the padding clears the accumulator, held and sent counts and returns to idle.
  `B32E_ASSERT_NEXT(a_pad_clears, (state_r == ST_PAD) && !sent_lt, (state_r == ST_IDLE) && (sent_r == '0) && (held_r == '0) && (acc_r == '0), "state not cleared after padding")

endmodule
